>>> rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared widths and the per-cell record of the swept sphere contact pipeline.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int unsigned CoordWidth   = 32;
  localparam int unsigned TimeFracBits = 16;

  localparam int unsigned RadWidth  = CoordWidth - 1;
  localparam int unsigned TimeWidth = TimeFracBits + 1;
  // magnitudes of sums of three squares or three products
  localparam int unsigned SumWidth  = 2 * CoordWidth + 2;
  // split of a SumWidth value for the partial products
  localparam int unsigned LoWidth   = (SumWidth + 1) / 2;
  localparam int unsigned HiWidth   = SumWidth - LoWidth;
  localparam int unsigned ProdWidth = 2 * SumWidth;
  // working width of the time search, signed
  localparam int unsigned SrchWidth = SumWidth + 2 * TimeFracBits + 4;
  localparam int unsigned NumCells  = TimeFracBits + 1;

  localparam int unsigned InDataWidth  = ((6 * CoordWidth + 2 * RadWidth + 7) / 8) * 8;
  localparam int unsigned OutDataWidth = ((1 + TimeWidth + 7) / 8) * 8;

  typedef struct packed {
    logic                 valid;
    logic                 touch;
    logic                 ok;
    logic [TimeWidth-1:0] k;
    logic [TimeWidth-1:0] m;
    logic [SrchWidth-1:0] f;
    logic [SrchWidth-1:0] g;
    logic [SrchWidth-1:0] a2;
    logic [SrchWidth-1:0] a1;
    logic [SrchWidth-1:0] s2;
    logic [SrchWidth-1:0] ak2;
  } cell_t;

endpackage

>>> rtl/ssc_front.sv
// ----------------------------------------------------------------------------
// ssc_front
// Forms a, s = -v.d and c, the discriminant and range tests, and seeds the
// time search cells. Five register stages.
// ----------------------------------------------------------------------------
module ssc_front import ssc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [InDataWidth-1:0]  data_i,
  output cell_t                   cell_o
);

  // stage 0: magnitudes
  logic [CoordWidth-1:0] dm_q [3];
  logic [CoordWidth-1:0] vm_q [3];
  logic [2:0]            neg_q;
  logic [CoordWidth-1:0] rsum_q;
  logic [3:0]            vld_q;

  // stage 1: products
  logic [2*CoordWidth-1:0] pdd_q [3];
  logic [2*CoordWidth-1:0] pvv_q [3];
  logic [2*CoordWidth-1:0] pdv_q [3];
  logic [2:0]              neg1_q;
  logic [2*CoordWidth-1:0] rr_q;

  // stage 2: a, c, s
  logic [SumWidth-1:0] aa_q;
  logic [SumWidth:0]   c_q;
  logic [SumWidth:0]   s_q;

  // stage 3: partial products and flags
  logic [SumWidth-1:0]          aa3_q, s3_q, c3_q;
  logic                         touch3_q, noroot3_q;
  logic [LoWidth+LoWidth-1:0]   pss_q [4];
  logic [LoWidth+LoWidth-1:0]   pac_q [4];

  cell_t cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // stage 0
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        logic [CoordWidth-1:0] d, v;
        d = data_i[i*CoordWidth +: CoordWidth];
        v = data_i[(i+3)*CoordWidth +: CoordWidth];
        dm_q[i]  <= d[CoordWidth-1] ? (~d + 1'b1) : d;
        vm_q[i]  <= v[CoordWidth-1] ? (~v + 1'b1) : v;
        neg_q[i] <= d[CoordWidth-1] ^ v[CoordWidth-1];
      end
      rsum_q <= {1'b0, data_i[6*CoordWidth +: RadWidth]}
              + {1'b0, data_i[6*CoordWidth+RadWidth +: RadWidth]};
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pdd_q[i] <= dm_q[i] * dm_q[i];
        pvv_q[i] <= vm_q[i] * vm_q[i];
        pdv_q[i] <= dm_q[i] * vm_q[i];
      end
      neg1_q <= neg_q;
      rr_q   <= rsum_q * rsum_q;
    end
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic [SumWidth-1:0] dd, aa, hp, hn;
      dd = '0; aa = '0; hp = '0; hn = '0;
      for (int i = 0; i < 3; i++) begin
        dd = dd + SumWidth'(pdd_q[i]);
        aa = aa + SumWidth'(pvv_q[i]);
        if (neg1_q[i]) hn = hn + SumWidth'(pdv_q[i]);
        else           hp = hp + SumWidth'(pdv_q[i]);
      end
      aa_q <= aa;
      c_q  <= {1'b0, dd} - {1'b0, SumWidth'(rr_q)};
      s_q  <= {1'b0, hn} - {1'b0, hp};
    end
  end

  // stage 3: split into 33-bit halves for the 66-bit partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic [SumWidth-1:0] su, cu;
      logic [LoWidth-1:0]  sl, sh, al, ah, cl, ch;
      su = s_q[SumWidth-1:0];
      cu = c_q[SumWidth-1:0];
      sl = su[LoWidth-1:0];
      sh = LoWidth'(su[SumWidth-1:LoWidth]);
      al = aa_q[LoWidth-1:0];
      ah = LoWidth'(aa_q[SumWidth-1:LoWidth]);
      cl = cu[LoWidth-1:0];
      ch = LoWidth'(cu[SumWidth-1:LoWidth]);
      pss_q[0] <= sl * sl;
      pss_q[1] <= sl * sh;
      pss_q[2] <= sh * sl;
      pss_q[3] <= sh * sh;
      pac_q[0] <= al * cl;
      pac_q[1] <= al * ch;
      pac_q[2] <= ah * cl;
      pac_q[3] <= ah * ch;
      aa3_q <= aa_q;
      s3_q  <= su;
      c3_q  <= cu;
      touch3_q  <= c_q[SumWidth] || (c_q == '0);
      // no root ahead: no motion, moving apart, or earlier root past 1.0
      noroot3_q <= (aa_q == '0) || s_q[SumWidth] || (s_q == '0)
                || ((su > aa_q) && (({1'b0, aa_q} + {1'b0, cu}) > {su, 1'b0}));
    end
  end

  // stage 4: discriminant and seeding of the search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.valid <= 1'b0;
    end else if (en_i) begin
      logic [2*ProdWidth-1:0] ss, ac;
      ss = (2*ProdWidth)'(pss_q[0])
         + ((2*ProdWidth)'(pss_q[1]) << LoWidth)
         + ((2*ProdWidth)'(pss_q[2]) << LoWidth)
         + ((2*ProdWidth)'(pss_q[3]) << (2*LoWidth));
      ac = (2*ProdWidth)'(pac_q[0])
         + ((2*ProdWidth)'(pac_q[1]) << LoWidth)
         + ((2*ProdWidth)'(pac_q[2]) << LoWidth)
         + ((2*ProdWidth)'(pac_q[3]) << (2*LoWidth));
      cell_q.valid <= vld_q[3];
      cell_q.touch <= touch3_q;
      cell_q.ok    <= !touch3_q && !noroot3_q && (ss >= ac);
      cell_q.k     <= '0;
      cell_q.m     <= TimeWidth'(1) << TimeFracBits;
      cell_q.f     <= SrchWidth'(c3_q) << (2*TimeFracBits);
      cell_q.g     <= SrchWidth'(s3_q) << TimeFracBits;
      cell_q.a2    <= SrchWidth'(aa3_q) << (2*TimeFracBits);
      cell_q.a1    <= SrchWidth'(aa3_q) << TimeFracBits;
      cell_q.s2    <= SrchWidth'(s3_q) << (2*TimeFracBits + 1);
      cell_q.ak2   <= '0;
    end
  end

  assign cell_o = cell_q;

endmodule

>>> rtl/ssc_cell.sv
// ----------------------------------------------------------------------------
// ssc_cell
// One bit of the contact time search: try setting the current time bit and
// keep it if the time stays at or before the earlier root.
// ----------------------------------------------------------------------------
module ssc_cell import ssc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cell_t cell_i,
  output cell_t cell_o
);

  cell_t cell_q;
  logic [SrchWidth-1:0] fn, gn;
  logic                 take;

  // f tracks a k^2 - 2 s k 2^F + c 2^2F, g tracks s 2^F - a k
  assign fn   = cell_i.f + cell_i.ak2 + cell_i.a2 - cell_i.s2;
  assign gn   = cell_i.g - cell_i.a1;
  assign take = cell_i.ok && !cell_i.k[TimeFracBits] && !gn[SrchWidth-1] && !fn[SrchWidth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.valid <= 1'b0;
    end else if (en_i) begin
      cell_q.valid <= cell_i.valid;
      cell_q.touch <= cell_i.touch;
      cell_q.ok    <= cell_i.ok;
      cell_q.k     <= take ? (cell_i.k | cell_i.m) : cell_i.k;
      cell_q.m     <= cell_i.m >> 1;
      cell_q.f     <= take ? fn : cell_i.f;
      cell_q.g     <= take ? gn : cell_i.g;
      cell_q.a2    <= cell_i.a2 >> 2;
      cell_q.a1    <= cell_i.a1 >> 1;
      cell_q.s2    <= cell_i.s2 >> 1;
      cell_q.ak2   <= (cell_i.ak2 >> 1) + (take ? cell_i.a2 : '0);
    end
  end

  assign cell_o = cell_q;

endmodule

>>> rtl/swept_sphere_sphere_contact.sv
// ----------------------------------------------------------------------------
// swept_sphere_sphere_contact
// Swept sphere pair test: hit flag and earliest contact time in the frame.
// ----------------------------------------------------------------------------
// Takes one sphere pair per cycle while not stalled and returns one result per
// pair, in order: five stages form the quadratic's terms and discriminant, a
// row of 17 cells finds the contact time one bit per cell, and one output
// register holds the result. The whole pipeline advances whenever the output
// register is empty or being taken.
module swept_sphere_sphere_contact import ssc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // start_dx, start_dy, start_dz, move_dx, move_dy, move_dz,
  // radius_first, radius_second, zero fill
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // hit, contact_time, zero fill
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  logic  en;
  cell_t chain [NumCells+1];
  logic                    out_valid_q;
  logic [OutDataWidth-1:0] out_data_q;

  assign en = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  ssc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .cell_o  (chain[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    ssc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain[NumCells].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= OutDataWidth'({chain[NumCells].ok ? chain[NumCells].k : '0,
                                   chain[NumCells].touch || chain[NumCells].ok});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
